// ===== src/dvru_pkg.sv =====
// Shared types, codes and constants for the distance-vector route update block.
// Used by dvru_update and by the top level distance_vector_route_update.
`timescale 1ns / 1ps

package dvru_pkg;

	// Field widths fixed by the request and result formats.
	localparam int COST_W      = 7;
	localparam int IDX_W_FIELD = 3;
	localparam int HOP_W       = 4;
	localparam int FIELD_LANES = 8;
	localparam int LINKS_W     = COST_W * FIELD_LANES;
	localparam int ROUTERS_DEF = 8;

	// Saturating "infinite" cost and the empty next-hop code.
	localparam logic [COST_W-1:0] INF_COST = 7'd99;
	localparam logic [HOP_W-1:0]  NO_HOP   = 4'd8;

	// Request action codes.
	localparam logic [2:0] ACT_VECTOR = 3'd0;
	localparam logic [2:0] ACT_LOOKUP = 3'd1;
	localparam logic [2:0] ACT_DEAD   = 3'd2;
	localparam logic [2:0] ACT_ALIVE  = 3'd3;
	localparam logic [2:0] ACT_START  = 3'd4;

	// Result status codes.
	localparam logic [2:0] ST_VECTOR_DONE = 3'd0;
	localparam logic [2:0] ST_DELIVERED   = 3'd1;
	localparam logic [2:0] ST_FORWARD     = 3'd2;
	localparam logic [2:0] ST_DROP        = 3'd3;
	localparam logic [2:0] ST_NOTICE      = 3'd4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINKS = 1'd1;

	typedef logic [COST_W-1:0] cost_t;

	// One request as held in the input register.
	typedef struct packed {
		logic [2:0]                        action;
		logic [IDX_W_FIELD-1:0]            source_router;
		logic [IDX_W_FIELD-1:0]            target_router;
		logic [FIELD_LANES-1:0][COST_W-1:0] cost;
	} dvru_req_t;

	// One result as held in the output register.
	typedef struct packed {
		logic [2:0]                        status;
		logic [HOP_W-1:0]                  next_hop;
		logic                              send_vector;
		logic [FIELD_LANES-1:0]            live_mask;
		logic [FIELD_LANES-1:0][COST_W-1:0] cost;
	} dvru_res_t;

	// Any 7-bit cost above the infinite value reads as infinite.
	function automatic cost_t clamp_cost(input logic [COST_W-1:0] v);
		return (v > INF_COST) ? INF_COST : v;
	endfunction

endpackage

// ===== src/dvru_update.sv =====
// Single-pass next-state and result logic for one route update request.
// Depends on dvru_pkg; instantiated by distance_vector_route_update.
`timescale 1ns / 1ps

module dvru_update #(
	parameter int LANES = 8
) (
	input  dvru_pkg::dvru_req_t                    req,
	input  logic [dvru_pkg::IDX_W_FIELD-1:0]       self_idx,
	input  logic [dvru_pkg::LINKS_W-1:0]           link_costs,
	input  logic [dvru_pkg::COST_W-1:0]            row_cur [LANES],
	input  logic [dvru_pkg::HOP_W-1:0]             hop_cur [LANES],
	input  logic [LANES-1:0]                       dead_cur,
	input  logic [LANES-1:0]                       live_cur,
	output logic [dvru_pkg::COST_W-1:0]            row_nxt [LANES],
	output logic [dvru_pkg::HOP_W-1:0]             hop_nxt [LANES],
	output logic [LANES-1:0]                       dead_nxt,
	output logic [LANES-1:0]                       live_nxt,
	output dvru_pkg::dvru_res_t                    res
);
	import dvru_pkg::*;

	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam logic [IDX_W_FIELD:0] LANES_L = (IDX_W_FIELD+1)'(LANES);

	logic             src_ok;
	logic             tgt_ok;
	logic [IDX_W-1:0] src_i;
	logic [IDX_W-1:0] tgt_i;
	cost_t            base;
	logic [HOP_W-1:0] tgt_hop;
	logic [LANES-1:0] rb_dead;
	logic [LANES-1:0] gain;
	cost_t            rb_row [LANES];
	logic [HOP_W-1:0] rb_hop [LANES];
	cost_t            rx_row [LANES];
	logic [HOP_W-1:0] rx_hop [LANES];
	logic             rx_changed;

	assign src_i   = req.source_router[IDX_W-1:0];
	assign tgt_i   = req.target_router[IDX_W-1:0];
	assign src_ok  = ({1'b0, req.source_router} < LANES_L) && (req.source_router != self_idx);
	assign tgt_ok  = ({1'b0, req.target_router} < LANES_L);
	assign base    = row_cur[src_i];
	assign tgt_hop = hop_cur[tgt_i];

	// Rebuild of the row from the link costs, used by start and dead notices.
	always_comb begin
		cost_t link_c;
		link_c  = INF_COST;
		rb_dead = dead_cur;
		if (req.action == ACT_DEAD && tgt_ok) begin
			rb_dead[tgt_i] = 1'b1;
		end
		for (int i = 0; i < LANES; i++) begin
			link_c    = clamp_cost(link_costs[COST_W*i +: COST_W]);
			rb_row[i] = link_c;
			gain[i]   = (self_idx != IDX_W_FIELD'(i)) && (link_c != '0) && (link_c < INF_COST);
			if (self_idx == IDX_W_FIELD'(i)) begin
				rb_row[i] = '0;
			end
			if (rb_dead[i]) begin
				rb_row[i] = INF_COST;
			end
			rb_hop[i] = ((rb_row[i] != '0) && (rb_row[i] < INF_COST)) ? HOP_W'(i) : NO_HOP;
		end
	end

	// One Bellman-Ford relaxation step over every lane in parallel.
	always_comb begin
		logic [COST_W:0] sum;
		sum        = '0;
		rx_changed = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			sum = {1'b0, clamp_cost(req.cost[i])} + {1'b0, base};
			if (sum > {1'b0, INF_COST}) begin
				sum = {1'b0, INF_COST};
			end
			rx_row[i] = row_cur[i];
			rx_hop[i] = hop_cur[i];
			if (src_ok && !dead_cur[i] && (sum[COST_W-1:0] < row_cur[i])) begin
				rx_row[i]  = sum[COST_W-1:0];
				rx_hop[i]  = {1'b0, req.source_router};
				rx_changed = 1'b1;
			end
		end
	end

	// Select the next state and the result by action.
	always_comb begin
		row_nxt         = row_cur;
		hop_nxt         = hop_cur;
		dead_nxt        = dead_cur;
		live_nxt        = live_cur;
		res.status      = ST_VECTOR_DONE;
		res.next_hop    = NO_HOP;
		res.send_vector = 1'b0;
		case (req.action)
			ACT_VECTOR: begin
				row_nxt         = rx_row;
				hop_nxt         = rx_hop;
				res.send_vector = rx_changed;
			end
			ACT_LOOKUP: begin
				if (!tgt_ok) begin
					res.status = ST_DROP;
				end else if (req.target_router == self_idx) begin
					res.status = ST_DELIVERED;
				end else if (tgt_hop != NO_HOP) begin
					res.status   = ST_FORWARD;
					res.next_hop = tgt_hop;
				end else begin
					res.status = ST_DROP;
				end
			end
			ACT_DEAD, ACT_START: begin
				row_nxt         = rb_row;
				hop_nxt         = rb_hop;
				dead_nxt        = rb_dead;
				live_nxt        = (live_cur | gain) & ~rb_dead;
				res.status      = ST_NOTICE;
				res.send_vector = 1'b1;
			end
			ACT_ALIVE: begin
				if (tgt_ok) begin
					dead_nxt[tgt_i] = 1'b0;
				end
				res.status = ST_NOTICE;
			end
			default: begin
				res.status = ST_VECTOR_DONE;
			end
		endcase

		// Every result carries the updated row and live flags.
		res.live_mask = '0;
		for (int j = 0; j < FIELD_LANES; j++) begin
			res.cost[j] = INF_COST;
		end
		for (int i = 0; i < LANES; i++) begin
			res.live_mask[i] = live_nxt[i];
			res.cost[i]      = row_nxt[i];
		end
	end

endmodule

// ===== src/distance_vector_route_update.sv =====
// Top level of the distance-vector route update block; uses dvru_pkg and dvru_update.
// Throughput: one request per cycle unless the receiver stalls; the input register, the update
// logic and the result register form a two-register pipeline, and state is written as the
// result is registered.
// Reset clears the pipeline, sets every distance to 99 and every next hop to none,
// clears the dead and live flags, and clears both configuration registers.
`timescale 1ns / 1ps

module distance_vector_route_update #(
	parameter int ROUTERS = dvru_pkg::ROUTERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dvru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dvru_pkg::LINKS_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          action,
	input  logic [dvru_pkg::IDX_W_FIELD-1:0]    source_router,
	input  logic [dvru_pkg::IDX_W_FIELD-1:0]    target_router,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_0,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_1,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_2,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_3,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_4,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_5,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_6,
	input  logic [dvru_pkg::COST_W-1:0]         cost_in_7,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          status,
	output logic [dvru_pkg::HOP_W-1:0]          next_hop,
	output logic                                send_vector,
	output logic [dvru_pkg::FIELD_LANES-1:0]    live_mask,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_0,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_1,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_2,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_3,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_4,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_5,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_6,
	output logic [dvru_pkg::COST_W-1:0]         cost_out_7
);
	import dvru_pkg::*;

	// Only the first eight routers are carried by the payload fields.
	localparam int LANES = (ROUTERS < FIELD_LANES) ? ROUTERS : FIELD_LANES;
	localparam logic [HOP_W-1:0] LANES_H = HOP_W'(LANES);

	// Configuration and routing state.
	logic [IDX_W_FIELD-1:0] self_q;
	logic [LINKS_W-1:0]     links_q;
	cost_t                  row_q  [LANES];
	logic [HOP_W-1:0]       hop_q  [LANES];
	logic [LANES-1:0]       dead_q;
	logic [LANES-1:0]       live_q;

	// Pipeline registers.
	logic       valid_s1;
	dvru_req_t  req_s1;
	logic       valid_s2;
	dvru_res_t  res_s2;

	cost_t            row_nxt [LANES];
	logic [HOP_W-1:0] hop_nxt [LANES];
	logic [LANES-1:0] dead_nxt;
	logic [LANES-1:0] live_nxt;
	dvru_res_t        res_nxt;
	logic             advance;

	// The result register frees when empty or when its request is taken.
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.action        <= action;
			req_s1.source_router <= source_router;
			req_s1.target_router <= target_router;
			req_s1.cost          <= {cost_in_7, cost_in_6, cost_in_5, cost_in_4,
				cost_in_3, cost_in_2, cost_in_1, cost_in_0};
		end
	end

	dvru_update #(
		.LANES(LANES)
	) u_update (
		.req        (req_s1),
		.self_idx   (self_q),
		.link_costs (links_q),
		.row_cur    (row_q),
		.hop_cur    (hop_q),
		.dead_cur   (dead_q),
		.live_cur   (live_q),
		.row_nxt    (row_nxt),
		.hop_nxt    (hop_nxt),
		.dead_nxt   (dead_nxt),
		.live_nxt   (live_nxt),
		.res        (res_nxt)
	);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// Routing state commits as the request moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				row_q[i] <= INF_COST;
				hop_q[i] <= NO_HOP;
			end
			dead_q <= '0;
			live_q <= '0;
		end else if (advance && valid_s1) begin
			row_q  <= row_nxt;
			hop_q  <= hop_nxt;
			dead_q <= dead_nxt;
			live_q <= live_nxt;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q  <= '0;
			links_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SELF:  self_q  <= cfg_data[IDX_W_FIELD-1:0];
				CFG_LINKS: links_q <= cfg_data;
				default:   self_q  <= self_q;
			endcase
		end
	end

	// Output ports.
	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign next_hop    = res_s2.next_hop;
	assign send_vector = res_s2.send_vector;
	assign live_mask   = res_s2.live_mask;
	assign cost_out_0  = res_s2.cost[0];
	assign cost_out_1  = res_s2.cost[1];
	assign cost_out_2  = res_s2.cost[2];
	assign cost_out_3  = res_s2.cost[3];
	assign cost_out_4  = res_s2.cost[4];
	assign cost_out_5  = res_s2.cost[5];
	assign cost_out_6  = res_s2.cost[6];
	assign cost_out_7  = res_s2.cost[7];

	// A router flagged dead is never a live neighbor.
	a_live_dead_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q & dead_q) == '0)
		else $error("live and dead flags overlap");

	// A forward result names a real router.
	a_forward_hop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FORWARD) |-> (next_hop < LANES_H))
		else $error("forward result without a valid next hop");

	// Any other result reports no next hop.
	a_no_hop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_FORWARD) |-> (next_hop == NO_HOP))
		else $error("next hop given on a non-forward result");

	// A request held by a full result register stays in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(req_s1)))
		else $error("held request lost from the input register");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for distance_vector_route_update.
// Depends on dvru_pkg for codes and request/result types; a scoreboard class predicts results.
`timescale 1ns / 1ps

module testbench;
	import dvru_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 100;
	localparam int PHASES         = 8;

	// Predicts the route table of one router and checks each result against it.
	class route_scoreboard;
		cost_t        row[FIELD_LANES];
		logic [3:0]   hop_tbl[FIELD_LANES];
		logic [7:0]   dead;
		logic [7:0]   live;
		logic [2:0]   self_id;
		logic [55:0]  links;
		dvru_res_t    expected_q[$];
		int           errors;

		function new();
			for (int i = 0; i < FIELD_LANES; i++) begin
				row[i] = INF_COST;
				hop_tbl[i] = NO_HOP;
			end
			dead = '0;
			live = '0;
			self_id = '0;
			links = '0;
			errors = 0;
		endfunction

		function cost_t saturate(logic [COST_W-1:0] v);
			return (v > INF_COST) ? INF_COST : v;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [LINKS_W-1:0] data);
			if (idx == CFG_SELF)
				self_id = data[2:0];
			else
				links = data;
		endfunction

		// Rebuild the row from the direct link costs, then force dead routers to infinite.
		function void rebuild();
			for (int i = 0; i < FIELD_LANES; i++) begin
				row[i] = saturate(links[COST_W*i +: COST_W]);
				hop_tbl[i] = NO_HOP;
				if (i != self_id && row[i] > 0 && row[i] < INF_COST)
					live[i] = 1'b1;
			end
			row[self_id] = '0;
			for (int i = 0; i < FIELD_LANES; i++) begin
				if (dead[i]) begin
					live[i] = 1'b0;
					row[i] = INF_COST;
				end
			end
			for (int i = 0; i < FIELD_LANES; i++) begin
				if (row[i] > 0 && row[i] < INF_COST)
					hop_tbl[i] = i[3:0];
			end
		endfunction

		// Apply one accepted request and queue the result it must produce.
		function void note_request(dvru_req_t r);
			dvru_res_t e;
			int        base;
			int        sum;
			e = '0;
			e.status = ST_VECTOR_DONE;
			e.next_hop = NO_HOP;
			e.send_vector = 1'b0;
			case (r.action)
				ACT_VECTOR: begin
					if (r.source_router != self_id) begin
						base = row[r.source_router];
						for (int i = 0; i < FIELD_LANES; i++) begin
							sum = saturate(r.cost[i]) + base;
							if (sum > INF_COST)
								sum = INF_COST;
							if (!dead[i] && sum < row[i]) begin
								row[i] = sum[COST_W-1:0];
								hop_tbl[i] = {1'b0, r.source_router};
								e.send_vector = 1'b1;
							end
						end
					end
				end
				ACT_LOOKUP: begin
					if (r.target_router == self_id) begin
						e.status = ST_DELIVERED;
					end else if (hop_tbl[r.target_router] != NO_HOP) begin
						e.status = ST_FORWARD;
						e.next_hop = hop_tbl[r.target_router];
					end else begin
						e.status = ST_DROP;
					end
				end
				ACT_DEAD: begin
					dead[r.target_router] = 1'b1;
					rebuild();
					e.status = ST_NOTICE;
					e.send_vector = 1'b1;
				end
				ACT_ALIVE: begin
					dead[r.target_router] = 1'b0;
					e.status = ST_NOTICE;
				end
				ACT_START: begin
					rebuild();
					e.status = ST_NOTICE;
					e.send_vector = 1'b1;
				end
				default: ;
			endcase
			e.live_mask = live;
			for (int i = 0; i < FIELD_LANES; i++)
				e.cost[i] = row[i];
			expected_q.push_back(e);
		endfunction

		// Compare one accepted result with the oldest outstanding prediction.
		function void check_result(dvru_res_t got);
			dvru_res_t e;
			if (expected_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.next_hop !== e.next_hop) begin
				$error("next_hop: expected %0d, got %0d", e.next_hop, got.next_hop);
				errors++;
			end
			if (got.send_vector !== e.send_vector) begin
				$error("send_vector: expected %0d, got %0d", e.send_vector, got.send_vector);
				errors++;
			end
			if (got.live_mask !== e.live_mask) begin
				$error("live_mask: expected %0h, got %0h", e.live_mask, got.live_mask);
				errors++;
			end
			for (int i = 0; i < FIELD_LANES; i++) begin
				if (got.cost[i] !== e.cost[i]) begin
					$error("cost_out_%0d: expected %0d, got %0d", i, e.cost[i], got.cost[i]);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void finish_check();
			if (expected_q.size() != 0) begin
				$error("%0d results never arrived", expected_q.size());
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SELF;
	logic [LINKS_W-1:0]    cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	dvru_req_t             drv_req = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            status;
	logic [HOP_W-1:0]      next_hop;
	logic                  send_vector;
	logic [7:0]            live_mask;
	cost_t                 cost_out[FIELD_LANES];

	route_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	distance_vector_route_update dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(drv_req.action), .source_router(drv_req.source_router),
		.target_router(drv_req.target_router),
		.cost_in_0(drv_req.cost[0]), .cost_in_1(drv_req.cost[1]),
		.cost_in_2(drv_req.cost[2]), .cost_in_3(drv_req.cost[3]),
		.cost_in_4(drv_req.cost[4]), .cost_in_5(drv_req.cost[5]),
		.cost_in_6(drv_req.cost[6]), .cost_in_7(drv_req.cost[7]),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .next_hop(next_hop), .send_vector(send_vector),
		.live_mask(live_mask),
		.cost_out_0(cost_out[0]), .cost_out_1(cost_out[1]),
		.cost_out_2(cost_out[2]), .cost_out_3(cost_out[3]),
		.cost_out_4(cost_out[4]), .cost_out_5(cost_out[5]),
		.cost_out_6(cost_out[6]), .cost_out_7(cost_out[7])
	);

	always #1 clk = ~clk;

	// The receiver stalls at random, at a rate set per phase.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor both channels at the rising edge; the watchdog counts quiet cycles.
	always @(posedge clk) begin
		dvru_res_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.status = status;
				got.next_hop = next_hop;
				got.send_vector = send_vector;
				got.live_mask = live_mask;
				for (int i = 0; i < FIELD_LANES; i++)
					got.cost[i] = cost_out[i];
				sb.check_result(got);
			end
			if (in_valid && !in_stall)
				sb.note_request(drv_req);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Costs are mostly short hops, with zero and infinite mixed in.
	function automatic cost_t pick_cost();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return cost_t'($urandom_range(1, 30));
			6:                return '0;
			7:                return INF_COST;
			default:          return cost_t'($urandom_range(0, 99));
		endcase
	endfunction

	function automatic dvru_req_t compose(logic [2:0] act, logic [2:0] src, logic [2:0] tgt,
			cost_t fill);
		dvru_req_t r;
		r.action = act;
		r.source_router = src;
		r.target_router = tgt;
		for (int i = 0; i < FIELD_LANES; i++)
			r.cost[i] = fill;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input dvru_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		drv_req <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [LINKS_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		sb.configure(idx, data);
	endtask

	// Wait until every predicted result has been seen, plus a little slack.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [LINKS_W-1:0] make_links(int kind);
		logic [LINKS_W-1:0] v;
		case (kind)
			1: v = '1;
			2: v = '0;
			3: v = LINKS_W'({$urandom, $urandom});
			default: begin
				for (int i = 0; i < FIELD_LANES; i++) begin
					if ($urandom_range(7) == 0)
						v[COST_W*i +: COST_W] = cost_t'($urandom_range(100, 127));
					else
						v[COST_W*i +: COST_W] = pick_cost();
				end
			end
		endcase
		return v;
	endfunction

	// Mostly vectors and lookups; notices and restarts keep the topology moving.
	task automatic send_random_item();
		dvru_req_t r;
		int        pick;
		pick = $urandom_range(99);
		r = compose(ACT_VECTOR, 3'($urandom_range(7)), 3'($urandom_range(7)), '0);
		for (int i = 0; i < FIELD_LANES; i++)
			r.cost[i] = pick_cost();
		if (pick < 50) begin
			if (r.source_router == sb.self_id && $urandom_range(3) != 0)
				r.source_router = r.source_router + 3'd1;
		end else if (pick < 76) begin
			r.action = ACT_LOOKUP;
		end else if (pick < 83) begin
			r.action = ACT_DEAD;
		end else if (pick < 91) begin
			r.action = ACT_ALIVE;
		end else begin
			r.action = ACT_START;
		end
		send_request(r);
	endtask

	initial begin
		dvru_req_t r;
		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: reset state first, then a hand-built topology.
		send_request(compose(ACT_LOOKUP, 3'd0, 3'd0, '0));
		send_request(compose(ACT_LOOKUP, 3'd0, 3'd5, '0));
		send_request(compose(ACT_VECTOR, 3'd3, 3'd0, '0));
		drain();
		write_register(CFG_SELF, LINKS_W'(2));
		write_register(CFG_LINKS, {7'd127, 7'd98, 7'd0, 7'd120, 7'd99, 7'd40, 7'd1, 7'd5});
		send_request(compose(ACT_START, 3'd0, 3'd0, '0));
		// A vector from this router itself is ignored.
		send_request(compose(ACT_VECTOR, 3'd2, 3'd0, '0));
		send_request(compose(ACT_VECTOR, 3'd1, 3'd0, '0));
		send_request(compose(ACT_VECTOR, 3'd6, 3'd0, INF_COST));
		r = compose(ACT_VECTOR, 3'd0, 3'd7, '0);
		r.cost = {7'd99, 7'd0, 7'd64, 7'd3, 7'd1, 7'd99, 7'd2, 7'd0};
		send_request(r);
		send_request(compose(ACT_LOOKUP, 3'd0, 3'd2, '0));
		send_request(compose(ACT_LOOKUP, 3'd0, 3'd1, '0));
		send_request(compose(ACT_LOOKUP, 3'd0, 3'd3, '0));
		send_request(compose(ACT_DEAD, 3'd0, 3'd1, '0));
		send_request(compose(ACT_VECTOR, 3'd0, 3'd0, '0));
		send_request(compose(ACT_LOOKUP, 3'd0, 3'd1, '0));
		// This router named dead, then revived.
		send_request(compose(ACT_DEAD, 3'd0, 3'd2, '0));
		send_request(compose(ACT_ALIVE, 3'd0, 3'd2, '0));
		send_request(compose(ACT_ALIVE, 3'd0, 3'd1, '0));
		send_request(compose(ACT_START, 3'd0, 3'd0, '0));
		send_request(compose(ACT_LOOKUP, 3'd0, 3'd7, '0));
		send_request(compose(ACT_VECTOR, 3'd7, 3'd0, INF_COST));
		send_request(compose(ACT_ALIVE, 3'd0, 3'd5, '0));
		send_request(compose(ACT_DEAD, 3'd0, 3'd7, '0));
		send_request(compose(ACT_START, 3'd7, 3'd0, '0));
		drain();

		// Random phases: each idling mode twice, with a fresh configuration per phase.
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			if (p == 0)
				write_register(CFG_SELF, '0);
			else if (p == 1)
				write_register(CFG_SELF, LINKS_W'(7));
			else
				write_register(CFG_SELF, LINKS_W'($urandom_range(7)));
			write_register(CFG_LINKS, make_links(p % 4));
			send_request(compose(ACT_START, 3'd0, 3'd0, '0));
			repeat (PHASE_ITEMS) send_random_item();
			drain();
		end

		sb.finish_check();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
